// ===== design/dqir_pkg.sv =====
// Shared constants and command/status codes for the indexed-remove deque.
`default_nettype none

package dqir_pkg;

   // Storage geometry
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Fixed field widths of the request and response ports
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== design/deque_with_indexed_remove.sv =====
// Top level: bounded deque with indexed read and gap-closing remove.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid/req_ready, cmd, value, index  | in
//   result  | rsp_valid/rsp_ready, data, status, count| out
//
// One request at a time, sequenced over a single slot-address unit and one
// RAM port pair. Push, append, failed and unknown requests pass execute and
// done; pop and read add a read state (registered RAM read). Remove loops a
// RAM read state and a write state per entry after the index. Synchronous
// reset empties the store at once; RAM contents are not cleared. A new
// request is taken while a finished result still waits on rsp_ready.
`default_nettype none

module deque_with_indexed_remove
   import dqir_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic [INDEX_W-1:0]  req_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [VALUE_W-1:0]       rsp_data,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_count
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic [INDEX_W-1:0]    index_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [PTR_W-1:0]      front_ff;
   logic [CNT_W-1:0]      k_ff;
   logic [VALUE_W-1:0]    res_data_ff;
   logic [STATUS_W-1:0]   res_status_ff;
   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [PTR_W-1:0]      slot_pos;
   logic [PTR_W-1:0]      slot;
   logic                  ram_we;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [63:0]           value_wide;
   logic [63:0]           rdata_wide;
   logic                  is_full;
   logic                  is_empty;
   logic                  out_of_range;
   logic                  more_after_idx;
   logic                  more_after_k;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   // Word width adaptation between ports and storage
   assign value_wide = 64'(value_ff);
   assign rdata_wide = 64'(ram_rdata);

   // Condition flags
   assign is_full        = (count_ff == CNT_W'(DEPTH));
   assign is_empty       = (count_ff == '0);
   assign out_of_range   = (16'(index_ff) >= 16'(count_ff));
   assign more_after_idx = ((16'(index_ff) + 16'd1) < 16'(count_ff));
   assign more_after_k   = (((CNT_W + 2)'(k_ff) + (CNT_W + 2)'(2)) < (CNT_W + 2)'(count_ff));

   dqir_slot u_slot (
      .front (front_ff),
      .pos   (slot_pos),
      .slot  (slot)
   );

   dqir_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot),
      .wr_data (ram_wdata),
      .rd_addr (slot),
      .rd_data (ram_rdata)
   );

   // Position fed to the shared slot unit, and RAM write control
   always_comb begin
      slot_pos  = '0;
      ram_we    = 1'b0;
      ram_wdata = ram_rdata;
      case (state_ff)
         S_EXEC: begin
            case (cmd_ff)
               CMD_PUSH_FRONT: begin
                  slot_pos  = PTR_W'(DEPTH - 1);
                  ram_we    = !is_full;
                  ram_wdata = value_wide[DATA_WIDTH-1:0];
               end
               CMD_APPEND: begin
                  slot_pos  = PTR_W'(count_ff);
                  ram_we    = !is_full;
                  ram_wdata = value_wide[DATA_WIDTH-1:0];
               end
               CMD_READ: begin
                  slot_pos = PTR_W'(index_ff);
               end
               default: begin
                  slot_pos = '0;
               end
            endcase
         end
         S_READ: begin
            slot_pos = PTR_W'(1);
         end
         S_SHIFT_RD: begin
            slot_pos = PTR_W'(k_ff + CNT_W'(1));
         end
         S_SHIFT_WR: begin
            slot_pos = PTR_W'(k_ff);
            ram_we   = 1'b1;
         end
         default: begin
            slot_pos = '0;
         end
      endcase
   end

   // Sequencer, store state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register drains; in S_DONE the load below decides instead
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_cmd;
                  value_ff <= req_value;
                  index_ff <= req_index;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_data_ff   <= '0;
               res_status_ff <= ST_OK;
               state_ff      <= S_DONE;
               case (cmd_ff)
                  CMD_PUSH_FRONT, CMD_APPEND: begin
                     if (is_full) begin
                        res_status_ff <= ST_FULL;
                     end else begin
                        if (cmd_ff == CMD_PUSH_FRONT) begin
                           front_ff <= slot;
                        end
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        res_status_ff <= ST_EMPTY;
                     end else begin
                        state_ff <= S_READ;
                     end
                  end
                  CMD_READ: begin
                     if (is_empty) begin
                        res_status_ff <= ST_EMPTY;
                     end else if (out_of_range) begin
                        res_status_ff <= ST_RANGE;
                     end else begin
                        state_ff <= S_READ;
                     end
                  end
                  CMD_REMOVE: begin
                     if (is_empty) begin
                        res_status_ff <= ST_EMPTY;
                     end else if (out_of_range) begin
                        res_status_ff <= ST_RANGE;
                     end else if (more_after_idx) begin
                        k_ff     <= CNT_W'(index_ff);
                        state_ff <= S_SHIFT_RD;
                     end else begin
                        count_ff <= count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     res_status_ff <= ST_OK;
                  end
               endcase
            end
            S_READ: begin
               // read data is back; a pop also moves the front up by one
               res_data_ff <= rdata_wide[VALUE_W-1:0];
               if (cmd_ff == CMD_POP_FRONT) begin
                  front_ff <= slot;
                  count_ff <= count_ff - CNT_W'(1);
               end
               state_ff <= S_DONE;
            end
            S_SHIFT_RD: begin
               state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               // entry k+1 has been written into slot of k
               k_ff <= k_ff + CNT_W'(1);
               if (more_after_k) begin
                  state_ff <= S_SHIFT_RD;
               end else begin
                  count_ff <= count_ff - CNT_W'(1);
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= res_data_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_count_ff  <= COUNT_W'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== design/dqir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dqir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/dqir_slot.sv =====
// Shared slot-address unit: maps a position from the front onto a ring slot.
`default_nettype none

module dqir_slot
   import dqir_pkg::*;
(
   input  wire logic [PTR_W-1:0] front,
   input  wire logic [PTR_W-1:0] pos,
   output logic      [PTR_W-1:0] slot
);

   logic [PTR_W:0] sum;

   // front + pos modulo DEPTH; both operands stay below DEPTH
   always_comb begin
      sum = (PTR_W + 1)'(front) + (PTR_W + 1)'(pos);
      if (sum >= (PTR_W + 1)'(DEPTH)) begin
         slot = PTR_W'(sum - (PTR_W + 1)'(DEPTH));
      end else begin
         slot = PTR_W'(sum);
      end
   end

endmodule

`default_nettype wire
